[design/tok_pkg.sv]
package tok_pkg;

	localparam int IdW    = 8;
	localparam int UnresW = 6;
	localparam int CfgIdxW = 3;
	localparam int CfgW   = 8;

	localparam logic [CfgIdxW-1:0] CFG_CUT_ENABLE  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_CUT_SOURCE  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_CUT_TARGET  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TAIL_ENABLE = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TAIL_NODE   = 3'd4;

	localparam logic           RST_CUT_ENABLE  = 1'b1;
	localparam logic [IdW-1:0] RST_CUT_SOURCE  = 8'd22;
	localparam logic [IdW-1:0] RST_CUT_TARGET  = 8'd21;
	localparam logic           RST_TAIL_ENABLE = 1'b1;
	localparam logic [IdW-1:0] RST_TAIL_NODE   = 8'd21;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_E_RD, ST_E_CMP, ST_E_CHK, ST_N_SCAN, ST_N_ADD,
		ST_R_LD, ST_R_CMP, ST_R_WR, ST_D_RD, ST_D_MAP, ST_D_INC,
		ST_SEED, ST_POP, ST_P_RD, ST_P_MAP, ST_P_DEC, ST_Z,
		ST_EM0, ST_EM_ITEM, ST_EM_TAIL, ST_EM_NONE, ST_FIN
	} tok_state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LATCH, OP_OVF, OP_N_SCAN, OP_N_ADD, OP_R_LD, OP_R_CMP,
		OP_R_WR, OP_D_INC, OP_SEED, OP_POP, OP_P_DEC, OP_Z, OP_EM0,
		OP_EM_ITEM, OP_EM_TAIL, OP_EM_NONE, OP_FIN
	} tok_op_t;

	typedef struct packed {
		tok_op_t op;
		logic    inc_i;
		logic    clr_i;
		logic    inc_j;
		logic    clr_j;
		logic    in_ready;
	} tok_cmd_t;

	typedef struct packed {
		logic dup;
		logic e_last;
		logic n_last_i;
		logic n_last_j;
		logic k_last;
		logic m_zero;
		logic n_zero;
		logic m_full;
		logic fit;
		logic q_empty;
		logic out_free;
		logic skip;
		logic total_zero;
		logic kahn_zero;
		logic tail_en;
	} tok_status_t;

endpackage

[design/tok_item_if.sv]
interface tok_item_if;
	import tok_pkg::*;
	logic           valid;
	logic           ready;
	logic           command;
	logic [IdW-1:0] src_id;
	logic [IdW-1:0] dst_id;
	modport source(output valid, command, src_id, dst_id, input ready);
	modport sink(input valid, command, src_id, dst_id, output ready);
endinterface

[design/tok_result_if.sv]
interface tok_result_if;
	import tok_pkg::*;
	logic              valid;
	logic              ready;
	logic [IdW-1:0]    node_id;
	logic              is_last;
	logic              no_node;
	logic [UnresW-1:0] unresolved;
	logic              overflow;
	modport source(output valid, node_id, is_last, no_node, unresolved, overflow,
		input ready);
	modport sink(input valid, node_id, is_last, no_node, unresolved, overflow,
		output ready);
endinterface

[design/tok_cfg_if.sv]
interface tok_cfg_if;
	import tok_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgW-1:0]    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/tok_ctrl.sv]
module tok_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_command,
	input  tok_pkg::tok_status_t st,
	output tok_pkg::tok_cmd_t    cmd
);
	import tok_pkg::*;

	tok_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.op = OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LATCH;
					cmd.clr_i = 1'b1;
					cmd.clr_j = 1'b1;
					if (in_command == CMD_ADD) begin
						state_d = st.m_zero ? ST_E_CHK : ST_E_RD;
					end else begin
						state_d = st.n_zero ? ST_EM0 : ST_R_LD;
					end
				end
			end
			// duplicate search, reading and then comparing each stored edge
			ST_E_RD: state_d = ST_E_CMP;
			ST_E_CMP: begin
				if (st.dup) begin
					state_d = ST_IDLE;
				end else if (st.e_last) begin
					state_d = ST_E_CHK;
				end else begin
					cmd.inc_i = 1'b1;
					state_d = ST_E_RD;
				end
			end
			ST_E_CHK: begin
				if (st.m_full) begin
					cmd.op = OP_OVF;
					state_d = ST_IDLE;
				end else begin
					state_d = st.n_zero ? ST_N_ADD : ST_N_SCAN;
				end
			end
			ST_N_SCAN: begin
				cmd.op = OP_N_SCAN;
				if (st.n_last_j) begin
					state_d = ST_N_ADD;
				end else begin
					cmd.inc_j = 1'b1;
				end
			end
			ST_N_ADD: begin
				cmd.op = st.fit ? OP_N_ADD : OP_OVF;
				state_d = ST_IDLE;
			end
			// rank every node by counting smaller ids
			ST_R_LD: begin
				cmd.op = OP_R_LD;
				cmd.clr_j = 1'b1;
				state_d = ST_R_CMP;
			end
			ST_R_CMP: begin
				cmd.op = OP_R_CMP;
				if (st.n_last_j) begin
					state_d = ST_R_WR;
				end else begin
					cmd.inc_j = 1'b1;
				end
			end
			ST_R_WR: begin
				cmd.op = OP_R_WR;
				if (st.n_last_i) begin
					cmd.clr_i = 1'b1;
					state_d = st.m_zero ? ST_SEED : ST_D_RD;
				end else begin
					cmd.inc_i = 1'b1;
					state_d = ST_R_LD;
				end
			end
			ST_D_RD: state_d = ST_D_MAP;
			ST_D_MAP: state_d = ST_D_INC;
			ST_D_INC: begin
				cmd.op = OP_D_INC;
				if (st.e_last) begin
					cmd.clr_i = 1'b1;
					state_d = ST_SEED;
				end else begin
					cmd.inc_i = 1'b1;
					state_d = ST_D_RD;
				end
			end
			ST_SEED: begin
				cmd.op = OP_SEED;
				if (st.n_last_i) begin
					cmd.clr_i = 1'b1;
					state_d = ST_POP;
				end else begin
					cmd.inc_i = 1'b1;
				end
			end
			ST_POP: begin
				cmd.clr_i = 1'b1;
				if (st.q_empty) begin
					state_d = ST_EM0;
				end else begin
					cmd.op = OP_POP;
					state_d = st.m_zero ? ST_Z : ST_P_RD;
				end
			end
			ST_P_RD: state_d = ST_P_MAP;
			ST_P_MAP: state_d = ST_P_DEC;
			ST_P_DEC: begin
				cmd.op = OP_P_DEC;
				if (st.e_last) begin
					cmd.clr_i = 1'b1;
					state_d = ST_Z;
				end else begin
					cmd.inc_i = 1'b1;
					state_d = ST_P_RD;
				end
			end
			// released nodes enter the queue in ascending id order
			ST_Z: begin
				cmd.op = OP_Z;
				if (st.n_last_i) begin
					cmd.clr_i = 1'b1;
					state_d = ST_POP;
				end else begin
					cmd.inc_i = 1'b1;
				end
			end
			ST_EM0: begin
				cmd.op = OP_EM0;
				cmd.clr_i = 1'b1;
				priority if (st.total_zero) begin
					state_d = ST_EM_NONE;
				end else if (st.kahn_zero) begin
					state_d = ST_EM_TAIL;
				end else begin
					state_d = ST_EM_ITEM;
				end
			end
			ST_EM_ITEM: begin
				cmd.op = OP_EM_ITEM;
				if (st.skip || st.out_free) begin
					if (st.k_last) begin
						state_d = st.tail_en ? ST_EM_TAIL : ST_FIN;
					end else begin
						cmd.inc_i = 1'b1;
					end
				end
			end
			ST_EM_TAIL: begin
				cmd.op = OP_EM_TAIL;
				if (st.out_free) state_d = ST_FIN;
			end
			ST_EM_NONE: begin
				cmd.op = OP_EM_NONE;
				if (st.out_free) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.op = OP_FIN;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[design/tok_datapath.sv]
module tok_datapath #(
	parameter int MAX_NODES = 32,
	parameter int MAX_EDGES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tok_pkg::tok_cmd_t            cmd,
	output tok_pkg::tok_status_t         st,
	input  logic [tok_pkg::IdW-1:0]      in_src,
	input  logic [tok_pkg::IdW-1:0]      in_dst,
	input  logic                         cfg_fire,
	input  logic [tok_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tok_pkg::CfgW-1:0]     cfg_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [tok_pkg::IdW-1:0]      out_node_id,
	output logic                         out_is_last,
	output logic                         out_no_node,
	output logic [tok_pkg::UnresW-1:0]   out_unresolved,
	output logic                         out_overflow
);
	import tok_pkg::*;

	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int NIW = $clog2(MAX_NODES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int DW  = EW;
	localparam int CW  = (NW > EW) ? NW : EW;
	localparam int TW  = NW + 1;
	localparam int MapDepth = 1 << IdW;

	// configuration
	logic           cut_en_q, tail_en_q;
	logic [IdW-1:0] cut_src_q, cut_dst_q, tail_node_q;

	// control registers
	logic [CW-1:0]  i_q;
	logic [NW-1:0]  j_q;
	logic [NW-1:0]  ncnt_q, head_q, tail_q;
	logic [EW-1:0]  ecnt_q;
	logic           ovf_q, sk_q, dk_q, tail_in_q;
	logic [TW-1:0]  total_q, emitted_q;
	logic [NW-1:0]  unres_q;

	// payload registers
	logic [IdW-1:0] s_q, d_q, vi_q, uid_q;
	logic [NIW-1:0] rank_q, tail_rank_q;

	// stores
	logic [IdW-1:0]   node_q   [MAX_NODES];
	logic [IdW-1:0]   sorted_q [MAX_NODES];
	logic [DW-1:0]    deg_q    [MAX_NODES];
	logic             zf_q     [MAX_NODES];
	logic [NIW-1:0]   fifo_q   [MAX_NODES];
	logic [2*IdW-1:0] edge_mem [MAX_EDGES];
	logic [NIW-1:0]   map_mem  [MapDepth];
	logic [2*IdW-1:0] edge_rd_q;
	logic [NIW-1:0]   map_q;

	logic [NIW-1:0] i_n, j_n, nraddr, deg_addr, fifo_addr;
	logic [EIW-1:0] i_e;
	logic [IdW-1:0] node_rd, es, ed, em_id;
	logic [DW-1:0]  deg_rd;
	logic [NIW-1:0] fifo_rd;
	logic           edge_cut, edge_act, tail_proc, fit;
	logic [NW:0]    need_sum;
	logic [NW-1:0]  ncnt_p1;
	logic [TW-1:0]  total_c;
	logic [NW-1:0]  unres_c;
	logic           out_free, em_last, out_set;

	assign i_n = i_q[NIW-1:0];
	assign i_e = i_q[EIW-1:0];
	assign j_n = j_q[NIW-1:0];
	assign nraddr = (cmd.op == OP_R_LD) ? i_n : j_n;
	assign node_rd = node_q[nraddr];
	assign es = edge_rd_q[2*IdW-1:IdW];
	assign ed = edge_rd_q[IdW-1:0];
	assign edge_cut = cut_en_q && (es == cut_src_q) && (ed == cut_dst_q);
	assign edge_act = (es == uid_q) && !edge_cut;

	always_comb begin
		unique case (cmd.op)
			OP_D_INC, OP_P_DEC: deg_addr = map_q;
			OP_EM0:             deg_addr = tail_rank_q;
			default:            deg_addr = i_n;
		endcase
	end
	assign deg_rd = deg_q[deg_addr];
	assign fifo_addr = (cmd.op == OP_POP) ? head_q[NIW-1:0] : i_n;
	assign fifo_rd = fifo_q[fifo_addr];
	assign em_id = sorted_q[fifo_rd];

	assign need_sum = (NW + 1)'(ncnt_q) + (NW + 1)'(!sk_q)
		+ (NW + 1)'((s_q != d_q) && !dk_q);
	assign fit = need_sum <= (NW + 1)'(MAX_NODES);
	assign ncnt_p1 = ncnt_q + NW'(1);

	// with the tail enabled, a processed tail node is taken out of the order and shown once at the end
	assign tail_proc = tail_in_q && (deg_rd == '0);
	assign total_c = TW'(tail_q) - TW'(tail_en_q && tail_proc) + TW'(tail_en_q);
	assign unres_c = ncnt_q - tail_q - NW'(tail_en_q && tail_in_q && !tail_proc);

	assign out_free = !out_valid || out_ready;
	assign em_last = (emitted_q + TW'(1)) == total_q;
	assign out_set = out_free && (((cmd.op == OP_EM_ITEM) && !st.skip)
		|| (cmd.op == OP_EM_TAIL) || (cmd.op == OP_EM_NONE));

	always_comb begin
		st = '0;
		st.dup        = edge_rd_q == {s_q, d_q};
		st.e_last     = (i_q + CW'(1)) == CW'(ecnt_q);
		st.n_last_i   = (i_q + CW'(1)) == CW'(ncnt_q);
		st.n_last_j   = (j_q + NW'(1)) == ncnt_q;
		st.k_last     = (i_q + CW'(1)) == CW'(tail_q);
		st.m_zero     = ecnt_q == '0;
		st.n_zero     = ncnt_q == '0;
		st.m_full     = ecnt_q == EW'(MAX_EDGES);
		st.fit        = fit;
		st.q_empty    = head_q == tail_q;
		st.out_free   = out_free;
		st.skip       = tail_en_q && (em_id == tail_node_q);
		st.total_zero = total_c == '0;
		st.kahn_zero  = tail_q == '0;
		st.tail_en    = tail_en_q;
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		edge_rd_q <= edge_mem[i_e];
		if (cmd.op == OP_N_ADD) edge_mem[ecnt_q[EIW-1:0]] <= {s_q, d_q};
	end

	always_ff @(posedge clk) begin
		map_q <= map_mem[ed];
		if (cmd.op == OP_R_WR) map_mem[vi_q] <= rank_q;
	end

	// tables and payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				s_q <= in_src;
				d_q <= in_dst;
			end
			OP_N_ADD: begin
				if (!sk_q) begin
					node_q[ncnt_q[NIW-1:0]] <= s_q;
					if ((s_q != d_q) && !dk_q) node_q[ncnt_p1[NIW-1:0]] <= d_q;
				end else if ((s_q != d_q) && !dk_q) begin
					node_q[ncnt_q[NIW-1:0]] <= d_q;
				end
			end
			OP_R_LD: begin
				vi_q <= node_rd;
				rank_q <= '0;
			end
			OP_R_CMP: rank_q <= rank_q + NIW'(node_rd < vi_q);
			OP_R_WR: begin
				sorted_q[rank_q] <= vi_q;
				deg_q[i_n] <= '0;
				zf_q[i_n] <= 1'b0;
				if (vi_q == tail_node_q) tail_rank_q <= rank_q;
			end
			OP_D_INC: if (!edge_cut) deg_q[map_q] <= deg_rd + DW'(1);
			OP_SEED: if (deg_rd == '0) fifo_q[tail_q[NIW-1:0]] <= i_n;
			OP_POP: uid_q <= em_id;
			OP_P_DEC: begin
				if (edge_act && (deg_rd != '0)) begin
					deg_q[map_q] <= deg_rd - DW'(1);
					if (deg_rd == DW'(1)) zf_q[map_q] <= 1'b1;
				end
			end
			OP_Z: begin
				if (zf_q[i_n]) begin
					fifo_q[tail_q[NIW-1:0]] <= i_n;
					zf_q[i_n] <= 1'b0;
				end
			end
			OP_EM0: unres_q <= unres_c;
			OP_EM_ITEM: begin
				if (!st.skip && out_free) begin
					out_node_id <= em_id;
					out_is_last <= em_last;
					out_no_node <= 1'b0;
					out_unresolved <= em_last ? UnresW'(unres_q) : '0;
					out_overflow <= ovf_q;
				end
			end
			OP_EM_TAIL: begin
				if (out_free) begin
					out_node_id <= tail_node_q;
					out_is_last <= 1'b1;
					out_no_node <= 1'b0;
					out_unresolved <= UnresW'(unres_q);
					out_overflow <= ovf_q;
				end
			end
			OP_EM_NONE: begin
				if (out_free) begin
					out_node_id <= '0;
					out_is_last <= 1'b1;
					out_no_node <= 1'b1;
					out_unresolved <= UnresW'(unres_q);
					out_overflow <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// counters, flags and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_en_q <= RST_CUT_ENABLE;
			cut_src_q <= RST_CUT_SOURCE;
			cut_dst_q <= RST_CUT_TARGET;
			tail_en_q <= RST_TAIL_ENABLE;
			tail_node_q <= RST_TAIL_NODE;
			i_q <= '0;
			j_q <= '0;
			ncnt_q <= '0;
			ecnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			ovf_q <= 1'b0;
			sk_q <= 1'b0;
			dk_q <= 1'b0;
			tail_in_q <= 1'b0;
			total_q <= '0;
			emitted_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_CUT_ENABLE:  cut_en_q <= cfg_data[0];
					CFG_CUT_SOURCE:  cut_src_q <= cfg_data;
					CFG_CUT_TARGET:  cut_dst_q <= cfg_data;
					CFG_TAIL_ENABLE: tail_en_q <= cfg_data[0];
					CFG_TAIL_NODE:   tail_node_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.clr_j) begin
				j_q <= '0;
			end else if (cmd.inc_j) begin
				j_q <= j_q + NW'(1);
			end
			out_valid <= out_set || (out_valid && !out_ready);
			unique case (cmd.op)
				OP_LATCH: begin
					sk_q <= 1'b0;
					dk_q <= 1'b0;
					tail_in_q <= 1'b0;
				end
				OP_OVF: ovf_q <= 1'b1;
				OP_N_SCAN: begin
					if (node_rd == s_q) sk_q <= 1'b1;
					if (node_rd == d_q) dk_q <= 1'b1;
				end
				OP_N_ADD: begin
					ncnt_q <= NW'(need_sum);
					ecnt_q <= ecnt_q + EW'(1);
				end
				OP_R_WR: if (vi_q == tail_node_q) tail_in_q <= 1'b1;
				OP_SEED: if (deg_rd == '0) tail_q <= tail_q + NW'(1);
				OP_POP: head_q <= head_q + NW'(1);
				OP_Z: if (zf_q[i_n]) tail_q <= tail_q + NW'(1);
				OP_EM0: begin
					total_q <= total_c;
					emitted_q <= '0;
				end
				OP_EM_ITEM: begin
					if (!st.skip && out_free) emitted_q <= emitted_q + TW'(1);
				end
				OP_FIN: begin
					ncnt_q <= '0;
					ecnt_q <= '0;
					head_q <= '0;
					tail_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

[design/topological_order_kahn.sv]
// channel  dir  handshake      payload
// items    in   valid/ready    command, src_id, dst_id
// results  out  valid/ready    node_id, is_last, no_node, unresolved, overflow
// cfg      in   valid/ready    index, data (ready always high)
//
// an edge is accepted, compared with each stored edge in the duplicate search,
// checked for room, compared with each stored node and inserted; a run ranks
// the nodes, counts degrees over the edges, seeds the queue and walks it, each
// popped node scanning all edges and then all nodes, then emits each queued
// node and a final result; the single-port edge memory sets the walk pace.
// reset clears counts and flags and loads the configuration defaults; tables need no clearing.
// a stalled result holds the emission; items are taken only between commands.
module topological_order_kahn #(
	parameter int MAX_NODES = 32,
	parameter int MAX_EDGES = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	tok_item_if.sink     items,
	tok_result_if.source results,
	tok_cfg_if.sink      cfg
);
	import tok_pkg::*;

	tok_cmd_t    ctl_cmd;
	tok_status_t dp_st;

	assign items.ready = ctl_cmd.in_ready;
	assign cfg.ready = 1'b1;

	tok_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_command(items.command),
		.st        (dp_st),
		.cmd       (ctl_cmd)
	);

	tok_datapath #(
		.MAX_NODES(MAX_NODES),
		.MAX_EDGES(MAX_EDGES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.st            (dp_st),
		.in_src        (items.src_id),
		.in_dst        (items.dst_id),
		.cfg_fire      (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.out_node_id   (results.node_id),
		.out_is_last   (results.is_last),
		.out_no_node   (results.no_node),
		.out_unresolved(results.unresolved),
		.out_overflow  (results.overflow)
	);

	a_no_node_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.no_node |-> results.is_last)
		else $error("empty-order result not marked last");

	a_unres_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.is_last |-> results.unresolved == '0)
		else $error("unresolved count on a non-final result");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && (items.command == CMD_RUN) |=> !items.ready)
		else $error("item taken right after a run transfer");

endmodule
